@@ rtl/csvs_pkg.sv @@
package csvs_pkg;

    localparam int OFFSET_BITS = 32;
    localparam int REC_BITS    = 32;

    localparam logic [7:0] QUOTE_CHAR   = 8'h22;
    localparam logic [7:0] NEWLINE_CHAR = 8'h0A;

    typedef logic [OFFSET_BITS-1:0] t_pos;
    typedef logic [REC_BITS-1:0]    t_rec;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
        logic       empty_buffer;
    } t_item;

endpackage

@@ rtl/csv_record_start_scanner.sv @@
// the result passes through the input register, then the result register, once the input item is accepted
// throughput: one byte per cycle while i_ready does not hold back the output; set by the flag and position update
// a byte that starts no record gives no result item
// reset: synchronous active low; clears quote flags, position and both valid bits,
// and arms a record start at offset zero
module csv_record_start_scanner
    import csvs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    input  logic       i_empty_buffer,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [31:0] o_record_start
);

    t_item in_item;
    t_item reg_item;
    logic  reg_valid;
    logic  core_ready;

    assign in_item.data_byte    = i_data_byte;
    assign in_item.last_byte    = i_last_byte;
    assign in_item.empty_buffer = i_empty_buffer;

    csvs_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (in_item),
        .o_valid (reg_valid),
        .i_ready (core_ready),
        .o_item  (reg_item)
    );

    csvs_scan_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (reg_valid),
        .o_ready        (core_ready),
        .i_item         (reg_item),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_record_start (o_record_start)
    );

endmodule

@@ rtl/csvs_in_reg.sv @@
module csvs_in_reg
    import csvs_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    output logic  o_valid,
    input  logic  i_ready,
    output t_item o_item
);

    logic  r_valid;
    t_item r_item;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

@@ rtl/csvs_scan_core.sv @@
module csvs_scan_core
    import csvs_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    output logic  o_valid,
    input  logic  i_ready,
    output t_rec  o_record_start
);

    logic r_iq;
    logic r_qp;
    logic r_sp;
    t_pos r_pos;
    logic r_out_valid;
    t_rec r_out_rec;

    logic n_iq;
    logic n_qp;
    logic n_sp;
    t_pos n_pos;
    logic advance;
    logic emit;
    logic is_quote;
    logic is_nl;
    logic esc;
    logic iq_mid;
    logic eff_quote;
    t_rec rec_val;

    assign o_ready = !r_out_valid || i_ready;
    assign advance = i_valid && o_ready;
    assign o_valid = r_out_valid;
    assign o_record_start = r_out_rec;

    always_comb begin
        is_quote  = (i_item.data_byte == QUOTE_CHAR);
        is_nl     = (i_item.data_byte == NEWLINE_CHAR);
        esc       = r_qp && is_quote;
        iq_mid    = (r_qp && !is_quote) ? 1'b0 : r_iq;
        eff_quote = is_quote && !esc;
        emit      = i_item.empty_buffer || r_sp;
        rec_val   = i_item.empty_buffer ? '0 : REC_BITS'(r_pos);
        n_qp      = eff_quote && iq_mid;
        n_iq      = iq_mid || eff_quote;
        n_sp      = is_nl && !iq_mid;
        n_pos     = (r_pos == '1) ? r_pos : r_pos + t_pos'(1);
        // end of buffer or empty marker returns to the start of a buffer
        if (i_item.empty_buffer || i_item.last_byte) begin
            n_qp  = 1'b0;
            n_iq  = 1'b0;
            n_sp  = 1'b1;
            n_pos = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iq        <= 1'b0;
            r_qp        <= 1'b0;
            r_sp        <= 1'b1;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_iq  <= n_iq;
                r_qp  <= n_qp;
                r_sp  <= n_sp;
                r_pos <= n_pos;
            end
            if (o_ready) begin
                r_out_valid <= advance && emit;
            end
        end
        if (advance && emit) begin
            r_out_rec <= rec_val;
        end
    end

    a_qp_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_qp |-> r_iq)
        else $error("quote pending outside quotes");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && i_item.empty_buffer |=> r_out_valid && r_out_rec == '0)
        else $error("empty buffer did not report offset zero");

    a_last_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && i_item.last_byte |=> r_pos == '0 && r_sp && !r_iq)
        else $error("state not restored after last item");

    a_sat_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_pos == '1 && !i_item.last_byte && !i_item.empty_buffer
        |=> r_pos == '1)
        else $error("position left saturation");

endmodule

@@ test/csv_record_start_scanner_tb.sv @@
module csv_record_start_scanner_tb
    import csvs_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY     = 2;
    localparam int STALL_LIMIT = 1000;
    localparam int ITEM_TARGET = 1550;

    class record_start_board;
        bit   quote_open;
        bit   quote_seen;
        bit   start_armed;
        t_pos position;
        t_rec starts_due[$];
        int   mismatches;

        function new();
            clear_scan();
            mismatches = 0;
        endfunction

        function void clear_scan();
            quote_open  = 1'b0;
            quote_seen  = 1'b0;
            start_armed = 1'b1;
            position    = '0;
        endfunction

        function void note_item(logic [7:0] data, logic last, logic empty);
            bit escaped;
            escaped = 1'b0;
            if (empty) begin
                starts_due.push_front('0);
                clear_scan();
                return;
            end
            if (start_armed) begin
                starts_due.push_front(t_rec'(position));
                start_armed = 1'b0;
            end
            if (quote_seen) begin
                quote_seen = 1'b0;
                if (data == QUOTE_CHAR) begin
                    escaped = 1'b1;
                end else begin
                    quote_open = 1'b0;
                end
            end
            if (!escaped) begin
                if (data == QUOTE_CHAR) begin
                    if (quote_open) begin
                        quote_seen = 1'b1;
                    end else begin
                        quote_open = 1'b1;
                    end
                end else if (data == NEWLINE_CHAR && !quote_open) begin
                    start_armed = 1'b1;
                end
            end
            if (position != '1) begin
                position++;
            end
            if (last) begin
                clear_scan();
            end
        endfunction

        function void check_result(t_rec got);
            t_rec want;
            if (starts_due.size() == 0) begin
                mismatches++;
                $display("%0t ns record_start: expected none, actual %0d", $time, got);
                return;
            end
            want = starts_due.pop_back();
            if (got !== want) begin
                mismatches++;
                $display("%0t ns record_start: expected %0d, actual %0d", $time, want, got);
            end
        endfunction

        function int pending();
            return starts_due.size();
        endfunction
    endclass

    logic       i_clk          = 1'b0;
    logic       i_rst_n        = 1'b0;
    logic       i_valid        = 1'b0;
    logic [7:0] i_data_byte    = 8'h00;
    logic       i_last_byte    = 1'b0;
    logic       i_empty_buffer = 1'b0;
    logic       i_ready        = 1'b0;
    logic       o_ready;
    logic       o_valid;
    logic [31:0] o_record_start;

    record_start_board board = new();
    bit pace_on   = 1'b1;
    bit run_done  = 1'b0;
    int items_sent = 0;
    int quiet_cycles = 0;

    csv_record_start_scanner u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_data_byte    (i_data_byte),
        .i_last_byte    (i_last_byte),
        .i_empty_buffer (i_empty_buffer),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_record_start (o_record_start)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // entered and left at a rising edge
    task automatic send_item(logic [7:0] data, logic last, logic empty);
        int gap;
        bit taken;
        gap = pace_on ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_data_byte    <= data;
        i_last_byte    <= last;
        i_empty_buffer <= empty;
        taken = 1'b0;
        while (!taken) begin
            @(negedge i_clk);
            taken = o_ready;
            @(posedge i_clk);
        end
        board.note_item(data, last, empty);
        items_sent++;
    endtask

    task automatic send_text(string text, bit close);
        for (int i = 0; i < text.len(); i++) begin
            send_item(text[i], close && (i == text.len() - 1), 1'b0);
        end
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (LATENCY + 2) @(posedge i_clk);
    endtask

    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 22) return QUOTE_CHAR;
        if (r < 40) return NEWLINE_CHAR;
        if (r < 52) return 8'h2C;
        if (r < 85) return 8'h61 + 8'($urandom_range(0, 25));
        return 8'($urandom_range(0, 255));
    endfunction

    initial begin
        int  len;
        int  cut;
        bit  noise;
        bit  paused;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed
        send_item(8'hFF, 1'b1, 1'b1);
        send_text("\n", 1'b1);
        send_text("a\nb", 1'b1);
        send_text("\"\"\"\n\"\nz", 1'b1);
        send_text("\"x", 1'b1);
        send_item(8'hFF, 1'b0, 1'b0);
        send_item(8'h00, 1'b1, 1'b0);
        send_text("q\n", 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
        drain();

        // random buffers
        paused = 1'b0;
        while (items_sent < ITEM_TARGET) begin
            pace_on = ($urandom_range(0, 3) != 0);
            len   = ($urandom_range(0, 15) == 0) ? $urandom_range(25, 60)
                                                 : $urandom_range(0, 12);
            noise = ($urandom_range(0, 9) == 0);
            cut   = ($urandom_range(0, 14) == 0) ? $urandom_range(0, len) : -1;
            if (len == 0) begin
                send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
            end else begin
                for (int i = 0; i < len; i++) begin
                    if (i == cut) begin
                        send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
                        break;
                    end
                    send_item(noise ? 8'($urandom_range(0, 255)) : pick_byte(),
                              i == len - 1, 1'b0);
                end
            end
            if (!paused && items_sent > ITEM_TARGET / 2) begin
                paused = 1'b1;
                drain();
            end
        end

        i_valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
        run_done = 1'b1;
        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        int   stall;
        bit   got;
        t_rec seen;
        repeat (12) @(posedge i_clk);
        forever begin
            stall = pace_on ? $urandom_range(0, 3) : 0;
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            got = 1'b0;
            while (!got) begin
                @(negedge i_clk);
                got  = o_valid;
                seen = o_record_start;
                @(posedge i_clk);
            end
            board.check_result(seen);
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n && !run_done) begin
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

endmodule
